[design/blpg_pkg.sv]
package blpg_pkg;

  // Coordinate and field widths
  localparam int COORD_BITS = 9;
  localparam int ROW_SHIFT  = 10;
  localparam int X_BITS     = 9;
  localparam int Y_BITS     = 8;
  localparam int COLOR_BITS = 16;
  localparam int ADDR_BITS  = 32;
  localparam int ERR_BITS   = COORD_BITS + 2;

  // Configuration port
  localparam int DATA_BITS    = 32;
  localparam int PADDR_BITS   = 3;
  localparam int REG_IDX_BITS = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_BASE = 1'b0;
  localparam logic [ADDR_BITS-1:0] FRAME_BASE_RESET = 32'h0800_0000;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_BITS   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Classified command: a step, or a load with its line setup done
  typedef struct packed {
    op_t                   op;
    logic                  steep;
    coord_t                major_pos;
    coord_t                major_end;
    coord_t                minor_pos;
    logic                  minor_dir_neg;
    coord_t                major_delta;
    coord_t                minor_delta;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

endpackage

[design/blpg_line_if.sv]
interface blpg_line_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [blpg_pkg::X_BITS-1:0]    start_x;
  logic [blpg_pkg::Y_BITS-1:0]    start_y;
  logic [blpg_pkg::X_BITS-1:0]    end_x;
  logic [blpg_pkg::Y_BITS-1:0]    end_y;
  logic [blpg_pkg::COLOR_BITS-1:0] pen_color;

  modport source (
    output valid, operation, start_x, start_y, end_x, end_y, pen_color,
    input  ready
  );
  modport sink (
    input  valid, operation, start_x, start_y, end_x, end_y, pen_color,
    output ready
  );
endinterface

[design/blpg_pixel_if.sv]
interface blpg_pixel_if;
  logic                            valid;
  logic                            ready;
  logic [blpg_pkg::X_BITS-1:0]     pixel_x;
  logic [blpg_pkg::Y_BITS-1:0]     pixel_y;
  logic [blpg_pkg::ADDR_BITS-1:0]  pixel_address;
  logic [blpg_pkg::COLOR_BITS-1:0] pixel_color;
  logic                            last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
    output ready
  );
endinterface

[design/blpg_cmd_fifo.sv]
module blpg_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  blpg_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output blpg_pkg::cmd_t rd_data
);

  blpg_pkg::cmd_t                     mem [blpg_pkg::FIFO_DEPTH];
  logic [blpg_pkg::PTR_BITS-1:0]      wr_ptr;
  logic [blpg_pkg::PTR_BITS-1:0]      rd_ptr;
  logic [blpg_pkg::CNT_BITS-1:0]      count;
  logic                               push;
  logic                               pop;

  assign wr_ready = (count != blpg_pkg::CNT_BITS'(blpg_pkg::FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // Store entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == blpg_pkg::PTR_BITS'(blpg_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == blpg_pkg::PTR_BITS'(blpg_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/blpg_front.sv]
module blpg_front (
  blpg_line_if.sink       line_in,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output blpg_pkg::cmd_t  cmd
);

  blpg_pkg::coord_t x0, y0, x1, y1;
  blpg_pkg::coord_t dx, dy;
  blpg_pkg::coord_t a0, b0, a1, b1;
  blpg_pkg::coord_t lo_a, lo_b, hi_a, hi_b;
  logic             steep;

  assign line_in.ready = cmd_ready;
  assign cmd_valid     = line_in.valid;

  // Classify the item and set up a line on load
  always_comb begin
    x0 = blpg_pkg::COORD_BITS'(line_in.start_x);
    y0 = blpg_pkg::COORD_BITS'(line_in.start_y);
    x1 = blpg_pkg::COORD_BITS'(line_in.end_x);
    y1 = blpg_pkg::COORD_BITS'(line_in.end_y);
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    steep = (dy > dx);

    // swap axes on a steep line
    if (steep) begin
      a0 = y0; b0 = x0; a1 = y1; b1 = x1;
    end else begin
      a0 = x0; b0 = y0; a1 = x1; b1 = y1;
    end

    // order endpoints so the major coordinate rises
    if (a0 > a1) begin
      lo_a = a1; lo_b = b1; hi_a = a0; hi_b = b0;
    end else begin
      lo_a = a0; lo_b = b0; hi_a = a1; hi_b = b1;
    end

    cmd.op            = blpg_pkg::op_t'(line_in.operation);
    cmd.steep         = steep;
    cmd.major_pos     = lo_a;
    cmd.major_end     = hi_a;
    cmd.minor_pos     = lo_b;
    cmd.major_delta   = hi_a - lo_a;
    cmd.minor_delta   = (hi_b > lo_b) ? hi_b - lo_b : lo_b - hi_b;
    cmd.minor_dir_neg = !(lo_b < hi_b);
    cmd.color         = line_in.pen_color;
  end

endmodule

[design/blpg_back.sv]
module blpg_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [blpg_pkg::ADDR_BITS-1:0]  frame_base,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  blpg_pkg::cmd_t                  cmd,
  blpg_pixel_if.source                    pixel_out
);

  // Line state
  logic                                  active, active_next;
  logic                                  steep, steep_next;
  blpg_pkg::coord_t                      major_pos, major_pos_next;
  blpg_pkg::coord_t                      major_end, major_end_next;
  blpg_pkg::coord_t                      minor_pos, minor_pos_next;
  logic                                  dir_neg, dir_neg_next;
  blpg_pkg::coord_t                      major_delta, major_delta_next;
  blpg_pkg::coord_t                      minor_delta, minor_delta_next;
  logic signed [blpg_pkg::ERR_BITS-1:0]  err, err_next;
  logic [blpg_pkg::COLOR_BITS-1:0]       color, color_next;

  // Output register
  logic                                  out_valid;
  logic [blpg_pkg::X_BITS-1:0]           out_x;
  logic [blpg_pkg::Y_BITS-1:0]           out_y;
  logic [blpg_pkg::ADDR_BITS-1:0]        out_addr;
  logic [blpg_pkg::COLOR_BITS-1:0]       out_color;
  logic                                  out_last;

  logic                                  slot_free;
  logic                                  is_load;
  logic                                  emit;
  logic                                  last;
  blpg_pkg::coord_t                      sx, sy;
  logic signed [blpg_pkg::ERR_BITS-1:0]  err_sum;
  logic [blpg_pkg::ADDR_BITS-1:0]        addr;

  assign slot_free = !out_valid || pixel_out.ready;
  assign is_load   = (cmd.op == blpg_pkg::OP_LOAD);
  // a load or a step with no line never waits for the output slot
  assign cmd_ready = is_load || !active || slot_free;
  assign emit      = cmd_valid && !is_load && active && slot_free;

  assign sx      = steep ? minor_pos : major_pos;
  assign sy      = steep ? major_pos : minor_pos;
  assign last    = (major_pos == major_end);
  assign err_sum = err + $signed({2'b00, minor_delta});
  assign addr    = frame_base
                 + (blpg_pkg::ADDR_BITS'(sy) << blpg_pkg::ROW_SHIFT)
                 + (blpg_pkg::ADDR_BITS'(sx) << 1);

  // Next line state
  always_comb begin
    active_next      = active;
    steep_next       = steep;
    major_pos_next   = major_pos;
    major_end_next   = major_end;
    minor_pos_next   = minor_pos;
    dir_neg_next     = dir_neg;
    major_delta_next = major_delta;
    minor_delta_next = minor_delta;
    err_next         = err;
    color_next       = color;
    if (cmd_valid && is_load) begin
      active_next      = 1'b1;
      steep_next       = cmd.steep;
      major_pos_next   = cmd.major_pos;
      major_end_next   = cmd.major_end;
      minor_pos_next   = cmd.minor_pos;
      dir_neg_next     = cmd.minor_dir_neg;
      major_delta_next = cmd.major_delta;
      minor_delta_next = cmd.minor_delta;
      err_next         = '0 - $signed({2'b00, cmd.major_delta >> 1});
      color_next       = cmd.color;
    end else if (emit) begin
      err_next = err_sum;
      if (err_sum > 0) begin
        minor_pos_next = dir_neg ? minor_pos - 1'b1 : minor_pos + 1'b1;
        err_next       = err_sum - $signed({2'b00, major_delta});
      end
      if (last) begin
        active_next = 1'b0;
      end else begin
        major_pos_next = major_pos + 1'b1;
      end
    end
  end

  // Hold line control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else begin
      active <= active_next;
    end
  end

  // Line payload state
  always_ff @(posedge clk) begin
    steep       <= steep_next;
    major_pos   <= major_pos_next;
    major_end   <= major_end_next;
    minor_pos   <= minor_pos_next;
    dir_neg     <= dir_neg_next;
    major_delta <= major_delta_next;
    minor_delta <= minor_delta_next;
    err         <= err_next;
    color       <= color_next;
  end

  // Output register valid: drop on transfer, set on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= blpg_pkg::X_BITS'(sx);
      out_y     <= blpg_pkg::Y_BITS'(sy);
      out_addr  <= addr;
      out_color <= color;
      out_last  <= last;
    end
  end

  assign pixel_out.valid         = out_valid;
  assign pixel_out.pixel_x       = out_x;
  assign pixel_out.pixel_y       = out_y;
  assign pixel_out.pixel_address = out_addr;
  assign pixel_out.pixel_color   = out_color;
  assign pixel_out.last_pixel    = out_last;

endmodule

[design/bresenham_line_pixel_generator.sv]
// Channel     Dir  Transfer               Payload
// line_in     in   valid && ready         operation, endpoints, pen_color
// pixel_out   out  valid && ready         pixel_x/y, pixel_address, color, last
// apb         in   psel&&penable&&pwrite  frame_base at address 0
//
// One item per cycle: a load or a step leaves the two-entry command queue each
// cycle unless a step waits on a stalled output; a step with a line gives one
// pixel into the output register, valid in the cycle after the step is taken.
// rst (synchronous, active high) empties the queue, ends any line, drops the
// output register and sets frame_base to 0x08000000.
// A stalled output holds steps in the queue; loads and idle steps still drain.
module bresenham_line_pixel_generator (
  input  logic                             clk,
  input  logic                             rst,
  blpg_line_if.sink                        line_in,
  blpg_pixel_if.source                     pixel_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [blpg_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [blpg_pkg::DATA_BITS-1:0]   pwdata,
  output logic [blpg_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready
);

  logic [blpg_pkg::ADDR_BITS-1:0]    frame_base;
  logic [blpg_pkg::REG_IDX_BITS-1:0] reg_idx;
  blpg_pkg::cmd_t                    front_cmd;
  logic                              front_valid;
  logic                              front_ready;
  blpg_pkg::cmd_t                    head_cmd;
  logic                              head_valid;
  logic                              head_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[blpg_pkg::PADDR_BITS-1:2];

  // Frame base register write
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= blpg_pkg::FRAME_BASE_RESET;
    end else if (psel && penable && pwrite && reg_idx == blpg_pkg::REG_FRAME_BASE) begin
      frame_base <= pwdata;
    end
  end

  // Register read
  always_comb begin
    if (reg_idx == blpg_pkg::REG_FRAME_BASE) begin
      prdata = frame_base;
    end else begin
      prdata = '0;
    end
  end

  blpg_front u_front (
    .line_in   (line_in),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  blpg_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (head_valid),
    .rd_ready (head_ready),
    .rd_data  (head_cmd)
  );

  blpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .frame_base (frame_base),
    .cmd_valid  (head_valid),
    .cmd_ready  (head_ready),
    .cmd        (head_cmd),
    .pixel_out  (pixel_out)
  );

endmodule
